[hw/rtl/lobt_pkg.sv]
// Shared widths, register indexes and the result record of the laser-off and beam-trip detector.
package lobt_pkg;

    localparam int unsigned LASER_W   = 19;
    localparam int unsigned BEAM_W    = 13;
    localparam int unsigned CEIL_W    = 18;
    localparam int unsigned RUN_CFG_W = 16;
    localparam int unsigned LEVEL_W   = 12;
    localparam int unsigned RUN_W     = 17;
    localparam int unsigned CONFIRM_W = 7;
    localparam int unsigned OUT_IDX_W = 24;

    localparam int unsigned S_DATA_W  = 32;
    localparam int unsigned M_DATA_W  = 80;

    localparam int unsigned CFG_IDX_W  = 3;
    localparam int unsigned CFG_DATA_W = 19;

    localparam logic [CFG_IDX_W-1:0] REG_LASER_OFF_LEVEL     = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_LASER_VALID_CEILING = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_LASER_OFF_MIN_RUN   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_BEAM_TRIP_LEVEL     = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_BEAM_GOOD_LOW       = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_BEAM_GOOD_HIGH      = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_TRIP_LOOKBACK       = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_RECOVER_WAIT        = 3'd7;

    localparam logic [RUN_W-1:0] RUN_MAX = {RUN_W{1'b1}};

    // Result record, packed so that sample_index sits in the lowest bits.
    typedef struct packed {
        logic [3:0]           pad;
        logic                 beam_recovered;
        logic [OUT_IDX_W-1:0] beam_trip_start_index;
        logic                 beam_trip_begins;
        logic                 laser_off_ends;
        logic [OUT_IDX_W-1:0] laser_off_start_index;
        logic                 laser_off_begins;
        logic [OUT_IDX_W-1:0] sample_index;
    } result_t;

endpackage

[hw/rtl/laser_off_and_beam_trip_detector_top.sv]
// Laser-off and beam-trip detector: per-sample run tracking with a skid-buffered result stream.
//
// Usage:
//   s_ channel: one sample per transaction. s_tdata holds laser power and beam
//   current, s_tlast marks the final sample of a run. m_ channel: one result
//   per sample, carrying the sample index, laser-off begin/end flags with the
//   start index, and beam trip begin/recovery flags with the looked-back start.
//   Configuration: cfg_we writes cfg_data to register cfg_index; write only
//   while no transaction is in flight.
//   Throughput: one sample per cycle. All per-sample work is a single pass of
//   compares and counter updates feeding the result register, so the result of
//   an accepted sample is registered into the output slot, or into the skid slot while a result waits.
//   Stall: the result register is backed by a one-entry skid register, so a
//   sample is still taken while a result waits; s_tready drops only once both
//   are full and recovers the cycle after m_tready takes a result.
//   Reset: aresetn (synchronous, active low) empties both result slots, clears
//   the run state to sample index 0 and loads the register defaults.
//   After a final sample the run state clears and the next sample is index 0.
module laser_off_and_beam_trip_detector_top #(
    parameter int unsigned INDEX_BITS         = 24,
    parameter int unsigned TRIP_CONFIRM_COUNT = 100
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_tvalid,
    output logic                                s_tready,
    // [18:0] laser_power, [31:19] beam_current
    input  logic [lobt_pkg::S_DATA_W-1:0]       s_tdata,
    input  logic                                s_tlast,
    output logic                                m_tvalid,
    input  logic                                m_tready,
    // [23:0] sample_index, [24] laser_off_begins, [48:25] laser_off_start_index,
    // [49] laser_off_ends, [50] beam_trip_begins, [74:51] beam_trip_start_index,
    // [75] beam_recovered, [79:76] zero
    output logic [lobt_pkg::M_DATA_W-1:0]       m_tdata,
    input  logic                                cfg_we,
    input  logic [lobt_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [lobt_pkg::CFG_DATA_W-1:0]     cfg_data
);
    import lobt_pkg::*;

    localparam int unsigned BACK_W = RUN_CFG_W + 1;
    localparam int unsigned CMP_W  = (INDEX_BITS > BACK_W) ? INDEX_BITS : BACK_W;

    // configuration
    logic signed [LASER_W-1:0]   off_level_reg;
    logic [CEIL_W-1:0]           valid_ceiling_reg;
    logic [RUN_CFG_W-1:0]        off_min_run_reg;
    logic [LEVEL_W-1:0]          trip_level_reg;
    logic [LEVEL_W-1:0]          good_low_reg;
    logic [LEVEL_W-1:0]          good_high_reg;
    logic [RUN_CFG_W-1:0]        lookback_reg;
    logic [RUN_CFG_W-1:0]        recover_wait_reg;

    // run state
    logic [INDEX_BITS-1:0]       idx_reg, idx_next;
    logic [RUN_W-1:0]            run_reg, run_next;
    logic                        off_open_reg, off_open_next;
    logic [CONFIRM_W-1:0]        confirm_reg, confirm_next;
    logic                        trip_open_reg, trip_open_next;
    logic [RUN_CFG_W-1:0]        recover_reg, recover_next;

    // output slots
    logic                        out_valid_reg;
    logic                        skid_valid_reg;
    result_t                     out_reg;
    result_t                     skid_reg;
    result_t                     res;

    // datapath intermediates
    logic signed [LASER_W-1:0]   laser;
    logic signed [BEAM_W-1:0]    beam;
    logic                        last;
    logic                        accept;
    logic                        laser_le;
    logic                        laser_valid;
    logic [RUN_CFG_W-1:0]        min_run;
    logic [RUN_CFG_W-1:0]        wait_len;
    logic                        off_begin;
    logic                        off_end;
    logic                        off_open_mid;
    logic [INDEX_BITS-1:0]       off_start;
    logic                        beam_pos;
    logic                        trip_sample;
    logic                        good_sample;
    logic [CONFIRM_W-1:0]        confirm_inc;
    logic                        trip_begin;
    logic [BACK_W-1:0]           back;
    logic [INDEX_BITS-1:0]       trip_start;
    logic                        trip_open_mid;
    logic [RUN_CFG_W-1:0]        recover_base;
    logic [RUN_CFG_W-1:0]        recover_inc;
    logic                        recovered;

    assign laser  = s_tdata[LASER_W-1:0];
    assign beam   = s_tdata[LASER_W+BEAM_W-1:LASER_W];
    assign last   = s_tlast;
    assign accept = s_tvalid && s_tready;

    assign s_tready = !skid_valid_reg;
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_reg;

    // configuration writes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            off_level_reg     <= '0;
            valid_ceiling_reg <= {CEIL_W{1'b1}};
            off_min_run_reg   <= RUN_CFG_W'(1000);
            trip_level_reg    <= LEVEL_W'(320);
            good_low_reg      <= LEVEL_W'(800);
            good_high_reg     <= LEVEL_W'(3200);
            lookback_reg      <= RUN_CFG_W'(100);
            recover_wait_reg  <= RUN_CFG_W'(9600);
        end else if (cfg_we) begin
            unique case (cfg_index)
                REG_LASER_OFF_LEVEL:     off_level_reg     <= cfg_data;
                REG_LASER_VALID_CEILING: valid_ceiling_reg <= cfg_data[CEIL_W-1:0];
                REG_LASER_OFF_MIN_RUN:   off_min_run_reg   <= cfg_data[RUN_CFG_W-1:0];
                REG_BEAM_TRIP_LEVEL:     trip_level_reg    <= cfg_data[LEVEL_W-1:0];
                REG_BEAM_GOOD_LOW:       good_low_reg      <= cfg_data[LEVEL_W-1:0];
                REG_BEAM_GOOD_HIGH:      good_high_reg     <= cfg_data[LEVEL_W-1:0];
                REG_TRIP_LOOKBACK:       lookback_reg      <= cfg_data[RUN_CFG_W-1:0];
                REG_RECOVER_WAIT:        recover_wait_reg  <= cfg_data[RUN_CFG_W-1:0];
                default: ;
            endcase
        end
    end

    // per-sample update
    always_comb begin
        min_run  = (off_min_run_reg == '0) ? RUN_CFG_W'(1) : off_min_run_reg;
        wait_len = (recover_wait_reg == '0) ? RUN_CFG_W'(1) : recover_wait_reg;

        // laser path: off samples count first, then valid on-readings clear the run
        laser_le    = laser <= off_level_reg;
        laser_valid = !laser[LASER_W-1] && (laser[CEIL_W-1:0] < valid_ceiling_reg);
        if (laser_le) begin
            run_next = (run_reg == RUN_MAX) ? run_reg : run_reg + RUN_W'(1);
        end else if (laser_valid) begin
            run_next = '0;
        end else begin
            run_next = run_reg;
        end
        off_begin     = run_next == RUN_W'(min_run);
        off_start     = idx_reg - INDEX_BITS'(min_run) + INDEX_BITS'(1);
        off_open_mid  = off_open_reg || off_begin;
        off_end       = off_open_mid && ((run_next == '0) || last);
        off_open_next = off_open_mid && !off_end;

        // beam path
        beam_pos    = !beam[BEAM_W-1] && (beam != '0);
        trip_sample = beam_pos && (beam[LEVEL_W-1:0] <= trip_level_reg);
        good_sample = !beam[BEAM_W-1] && (beam[LEVEL_W-1:0] > good_low_reg)
                      && (beam[LEVEL_W-1:0] < good_high_reg);

        confirm_inc = confirm_reg + CONFIRM_W'(1);
        trip_begin  = 1'b0;
        if (trip_sample && !trip_open_reg) begin
            if (confirm_inc >= CONFIRM_W'(TRIP_CONFIRM_COUNT)) begin
                confirm_next = '0;
                trip_begin   = 1'b1;
            end else begin
                confirm_next = confirm_inc;
            end
        end else begin
            confirm_next = '0;
        end

        back = BACK_W'(lookback_reg) + BACK_W'(TRIP_CONFIRM_COUNT);
        if (CMP_W'(idx_reg) >= CMP_W'(back)) begin
            trip_start = idx_reg - INDEX_BITS'(back);
        end else begin
            trip_start = idx_reg;
        end

        // a trip confirmed here may already count toward recovery
        trip_open_mid  = trip_open_reg || trip_begin;
        recover_base   = trip_begin ? '0 : recover_reg;
        recover_inc    = recover_base + RUN_CFG_W'(1);
        recovered      = 1'b0;
        trip_open_next = trip_open_mid;
        recover_next   = recover_base;
        if (trip_open_mid) begin
            if (good_sample) begin
                if (recover_inc >= wait_len) begin
                    recover_next   = '0;
                    trip_open_next = 1'b0;
                    recovered      = 1'b1;
                end else begin
                    recover_next = recover_inc;
                end
            end else begin
                recover_next = '0;
            end
        end
        if (last && trip_open_next) begin
            trip_open_next = 1'b0;
            recovered      = 1'b1;
        end

        idx_next = idx_reg + INDEX_BITS'(1);

        // end of run: start over at index zero
        if (last) begin
            idx_next       = '0;
            run_next       = '0;
            off_open_next  = 1'b0;
            confirm_next   = '0;
            trip_open_next = 1'b0;
            recover_next   = '0;
        end

        res.pad                   = '0;
        res.sample_index          = OUT_IDX_W'(idx_reg);
        res.laser_off_begins      = off_begin;
        res.laser_off_start_index = off_begin ? OUT_IDX_W'(off_start) : '0;
        res.laser_off_ends        = off_end;
        res.beam_trip_begins      = trip_begin;
        res.beam_trip_start_index = trip_begin ? OUT_IDX_W'(trip_start) : '0;
        res.beam_recovered        = recovered;
    end

    // state and slot control
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            idx_reg        <= '0;
            run_reg        <= '0;
            off_open_reg   <= 1'b0;
            confirm_reg    <= '0;
            trip_open_reg  <= 1'b0;
            recover_reg    <= '0;
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else begin
            if (accept) begin
                idx_reg       <= idx_next;
                run_reg       <= run_next;
                off_open_reg  <= off_open_next;
                confirm_reg   <= confirm_next;
                trip_open_reg <= trip_open_next;
                recover_reg   <= recover_next;
            end
            priority if (out_valid_reg && m_tready) begin
                if (skid_valid_reg) begin
                    skid_valid_reg <= 1'b0;
                end else begin
                    out_valid_reg <= accept;
                end
            end else if (out_valid_reg) begin
                if (accept) begin
                    skid_valid_reg <= 1'b1;
                end
            end else begin
                out_valid_reg <= accept;
            end
        end
    end

    // result payload, no reset needed
    always_ff @(posedge aclk) begin
        priority if (out_valid_reg && m_tready) begin
            if (skid_valid_reg) begin
                out_reg <= skid_reg;
            end else if (accept) begin
                out_reg <= res;
            end
        end else if (out_valid_reg) begin
            if (accept) begin
                skid_reg <= res;
            end
        end else if (accept) begin
            out_reg <= res;
        end
    end

`ifndef SYNTH
    a_skid_behind_out: assert property (@(posedge aclk) disable iff (!aresetn)
        skid_valid_reg |-> out_valid_reg)
        else $error("skid slot full while output slot empty");

    a_run_restart: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready && s_tlast) |=> (idx_reg == '0 && !trip_open_reg))
        else $error("run state not cleared after final sample");

    a_confirm_idle_in_trip: assert property (@(posedge aclk) disable iff (!aresetn)
        trip_open_reg |-> (confirm_reg == '0))
        else $error("trip confirm count running while trip open");

    a_off_open_run: assert property (@(posedge aclk) disable iff (!aresetn)
        off_open_reg |-> (run_reg != '0))
        else $error("laser-off period open with empty off run");
`endif

endmodule

[tb/sv/laser_off_and_beam_trip_detector_top_tb.sv]
// Self-checking testbench for the laser-off and beam-trip detector stream block.
`timescale 1ns / 100ps

module laser_off_and_beam_trip_detector_top_tb;

    import lobt_pkg::*;

    localparam int TRIP_CONFIRM   = 100;
    localparam int DRAIN_CYCLES   = 8;
    localparam int WATCHDOG_LIMIT = 1000;
    localparam int RANDOM_RUN_LEN = 65;

    typedef enum {LASER_OFF, LASER_ON, LASER_BAD, LASER_NOISE} laser_mode_t;
    typedef enum {BEAM_TRIP, BEAM_GOOD, BEAM_OTHER, BEAM_NOISE} beam_mode_t;

    logic                  aclk;
    logic                  aresetn   = 1'b0;
    logic                  s_tvalid  = 1'b0;
    logic                  s_tready;
    // [18:0] laser_power, [31:19] beam_current
    logic [S_DATA_W-1:0]   s_tdata   = '0;
    logic                  s_tlast   = 1'b0;
    logic                  m_tvalid;
    logic                  m_tready  = 1'b0;
    // [23:0] sample_index, [24] laser_off_begins, [48:25] laser_off_start_index,
    // [49] laser_off_ends, [50] beam_trip_begins, [74:51] beam_trip_start_index,
    // [75] beam_recovered, [79:76] zero
    logic [M_DATA_W-1:0]   m_tdata;
    logic                  cfg_we    = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data  = '0;

    // Register shadow
    logic signed [18:0] off_level;
    logic [17:0]        valid_ceiling;
    logic [15:0]        off_min_run;
    logic [11:0]        trip_level;
    logic [11:0]        good_low;
    logic [11:0]        good_high;
    logic [15:0]        look_back;
    logic [15:0]        recover_len;

    // Run state shadow
    logic [23:0]        run_index;
    logic [RUN_W-1:0]   off_run;
    logic               off_open;
    logic [6:0]         confirm_cnt;
    logic               trip_open;
    logic [15:0]        recover_cnt;

    result_t            pending_reports[$];
    int                 mismatches  = 0;
    int                 idle_cycles = 0;
    bit                 idle_on     = 1'b1;

    laser_off_and_beam_trip_detector_top #(
        .INDEX_BITS        (24),
        .TRIP_CONFIRM_COUNT(TRIP_CONFIRM)
    ) dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .cfg_we   (cfg_we),
        .cfg_index(cfg_index),
        .cfg_data (cfg_data)
    );

    initial begin
        aclk = 1'b0;
        forever #2 aclk = ~aclk;
    end

    function automatic void clear_run();
        run_index   = '0;
        off_run     = '0;
        off_open    = 1'b0;
        confirm_cnt = '0;
        trip_open   = 1'b0;
        recover_cnt = '0;
    endfunction

    function automatic void reset_model();
        off_level     = 19'sd0;
        valid_ceiling = 18'd262143;
        off_min_run   = 16'd1000;
        trip_level    = 12'd320;
        good_low      = 12'd800;
        good_high     = 12'd3200;
        look_back     = 16'd100;
        recover_len   = 16'd9600;
        clear_run();
    endfunction

    // Advance the shadow by one sample and return the report it produces.
    function automatic result_t detect_events(input logic [31:0] data, input logic run_end);
        result_t            r;
        logic signed [18:0] laser_raw;
        logic signed [12:0] beam_raw;
        int                 laser, beam, level, ceil, min_run, need_good, back, idx;
        int                 tl, gl, gh;
        logic               trip_hit, good_hit;
        laser_raw = data[18:0];
        beam_raw  = data[31:19];
        laser     = laser_raw;
        beam      = beam_raw;
        level     = off_level;
        ceil      = valid_ceiling;
        tl        = trip_level;
        gl        = good_low;
        gh        = good_high;
        min_run   = (off_min_run == 0) ? 1 : int'(off_min_run);
        need_good = (recover_len == 0) ? 1 : int'(recover_len);
        idx       = run_index;
        r         = '0;
        r.sample_index = run_index;

        // Off readings count first, even when negative.
        if (laser <= level) begin
            if (off_run != RUN_MAX)
                off_run = off_run + 1'b1;
        end else if (laser >= 0 && laser < ceil) begin
            off_run = '0;
        end
        if (int'(off_run) == min_run) begin
            r.laser_off_begins      = 1'b1;
            r.laser_off_start_index = run_index - 24'(min_run) + 24'd1;
            off_open                = 1'b1;
        end
        if (off_open && (off_run == 0 || run_end)) begin
            r.laser_off_ends = 1'b1;
            off_open         = 1'b0;
        end

        trip_hit = beam > 0 && beam <= tl;
        good_hit = beam > gl && beam < gh;
        if (trip_hit && !trip_open) begin
            confirm_cnt = confirm_cnt + 1'b1;
            if (int'(confirm_cnt) >= TRIP_CONFIRM) begin
                confirm_cnt = '0;
                back = int'(look_back) + TRIP_CONFIRM;
                r.beam_trip_start_index = (idx >= back) ? run_index - 24'(back) : run_index;
                r.beam_trip_begins = 1'b1;
                trip_open          = 1'b1;
                recover_cnt        = '0;
            end
        end else begin
            confirm_cnt = '0;
        end
        // A freshly confirmed trip may already count toward recovery here.
        if (trip_open) begin
            if (good_hit) begin
                recover_cnt = recover_cnt + 1'b1;
                if (int'(recover_cnt) >= need_good) begin
                    recover_cnt      = '0;
                    trip_open        = 1'b0;
                    r.beam_recovered = 1'b1;
                end
            end else begin
                recover_cnt = '0;
            end
        end
        if (run_end && trip_open) begin
            trip_open        = 1'b0;
            r.beam_recovered = 1'b1;
        end

        if (run_end)
            clear_run();
        else
            run_index = run_index + 1'b1;
        return r;
    endfunction

    function automatic void compare_field(input string name, input logic [23:0] want,
                                          input logic [23:0] got);
        if (want !== got) begin
            $display("%0t: %s mismatch, expected %0h actual %0h", $time, name, want, got);
            mismatches++;
        end
    endfunction

    always @(posedge aclk) begin : report_check
        result_t got, want;
        if (aresetn) begin
            if (s_tvalid && s_tready)
                pending_reports.insert(pending_reports.size(),
                                       detect_events(s_tdata, s_tlast));
            if (m_tvalid && m_tready) begin
                got = m_tdata;
                if (pending_reports.size() == 0) begin
                    $display("%0t: unexpected result, expected none, actual %h", $time, m_tdata);
                    mismatches++;
                end else begin
                    want = pending_reports.pop_front();
                    compare_field("sample_index", want.sample_index, got.sample_index);
                    compare_field("laser_off_begins", want.laser_off_begins,
                                  got.laser_off_begins);
                    compare_field("laser_off_start_index", want.laser_off_start_index,
                                  got.laser_off_start_index);
                    compare_field("laser_off_ends", want.laser_off_ends, got.laser_off_ends);
                    compare_field("beam_trip_begins", want.beam_trip_begins,
                                  got.beam_trip_begins);
                    compare_field("beam_trip_start_index", want.beam_trip_start_index,
                                  got.beam_trip_start_index);
                    compare_field("beam_recovered", want.beam_recovered, got.beam_recovered);
                    compare_field("pad", want.pad, got.pad);
                end
            end
        end
    end

    always @(posedge aclk) begin
        if (!aresetn || cfg_we || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("laser_off_and_beam_trip_detector_top_tb NOT OK");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    // Result side: while idle_on is set, stall a random number of cycles before each transaction.
    initial begin : result_sink
        int hold;
        while (!aresetn) @(posedge aclk);
        forever begin
            hold = idle_on ? $urandom_range(0, 5) : 0;
            if (hold > 0) begin
                m_tready <= 1'b0;
                repeat (hold) @(posedge aclk);
            end
            m_tready <= 1'b1;
            @(posedge aclk);
            while (!m_tvalid) @(posedge aclk);
        end
    end

    task automatic send_sample(input logic [18:0] laser, input logic [12:0] beam,
                               input logic run_end);
        int gap;
        gap = idle_on ? $urandom_range(0, 5) : 0;
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {beam, laser};
        s_tlast  <= run_end;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
    endtask

    // Hold the sender until every report is in, then let the pipeline settle.
    task automatic wait_idle();
        s_tvalid <= 1'b0;
        while (pending_reports.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    task automatic put_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] value);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(posedge aclk);
    endtask

    task automatic load_config(input logic [18:0] lvl, input logic [17:0] ceil,
                               input logic [15:0] min_run, input logic [11:0] tl,
                               input logic [11:0] gl, input logic [11:0] gh,
                               input logic [15:0] lb, input logic [15:0] rw);
        put_reg(REG_LASER_OFF_LEVEL, lvl);
        put_reg(REG_LASER_VALID_CEILING, ceil);
        put_reg(REG_LASER_OFF_MIN_RUN, min_run);
        put_reg(REG_BEAM_TRIP_LEVEL, tl);
        put_reg(REG_BEAM_GOOD_LOW, gl);
        put_reg(REG_BEAM_GOOD_HIGH, gh);
        put_reg(REG_TRIP_LOOKBACK, lb);
        put_reg(REG_RECOVER_WAIT, rw);
        cfg_we        <= 1'b0;
        off_level     = lvl;
        valid_ceiling = ceil;
        off_min_run   = min_run;
        trip_level    = tl;
        good_low      = gl;
        good_high     = gh;
        look_back     = lb;
        recover_len   = rw;
    endtask

    task automatic send_beam_run(input int lo, input int hi, input int count);
        for (int i = 0; i < count; i++)
            send_sample(19'd500, 13'(lo + int'($urandom_range(0, hi - lo))), 1'b0);
    endtask

    function automatic logic [18:0] laser_value(input laser_mode_t mode);
        int lvl, ceil, lo, hi;
        lvl = off_level;
        ceil = valid_ceiling;
        lo = -262144;
        hi = 262143;
        case (mode)
            LASER_OFF: begin
                hi = lvl;
                // Stay near the level about half of the time.
                if ($urandom_range(0, 1) && lvl - 3 > -262144)
                    lo = lvl - 3;
            end
            LASER_ON: begin
                lo = (lvl + 1 > 0) ? lvl + 1 : 0;
                hi = ceil - 1;
            end
            LASER_BAD: begin
                if (lvl < -1 && $urandom_range(0, 1)) begin
                    lo = lvl + 1;
                    hi = -1;
                end else begin
                    lo = (ceil > lvl + 1) ? ceil : lvl + 1;
                end
            end
            default: ;
        endcase
        if (lo > hi) begin
            lo = -262144;
            hi = 262143;
        end
        return 19'(lo + int'($urandom_range(0, hi - lo)));
    endfunction

    function automatic logic [12:0] beam_value(input beam_mode_t mode);
        int tl, gl, gh, lo, hi;
        tl = trip_level;
        gl = good_low;
        gh = good_high;
        lo = -4096;
        hi = 4095;
        case (mode)
            BEAM_TRIP: begin
                lo = 1;
                hi = tl;
            end
            BEAM_GOOD: begin
                lo = gl + 1;
                hi = gh - 1;
            end
            BEAM_OTHER: begin
                case ($urandom_range(0, 3))
                    0: hi = 0;
                    1: begin lo = gl; hi = gl; end
                    2: begin lo = gh; hi = gh; end
                    default: begin lo = tl + 1; hi = tl + 1; end
                endcase
            end
            default: ;
        endcase
        if (lo > hi || hi > 4095) begin
            lo = -4096;
            hi = 4095;
        end
        return 13'(lo + int'($urandom_range(0, hi - lo)));
    endfunction

    task automatic random_samples(input int count);
        laser_mode_t lmode;
        beam_mode_t  bmode;
        int          lleft, bleft, pick, span;
        lleft = 0;
        bleft = 0;
        lmode = LASER_NOISE;
        bmode = BEAM_NOISE;
        for (int i = 0; i < count; i++) begin
            if (lleft == 0) begin
                pick = $urandom_range(0, 99);
                span = (off_min_run > 100) ? 200 : 2 * int'(off_min_run) + 2;
                if (pick < 40) begin
                    lmode = LASER_OFF;
                    lleft = $urandom_range(1, span);
                end else if (pick < 70) begin
                    lmode = LASER_ON;
                    lleft = $urandom_range(1, 8);
                end else if (pick < 85) begin
                    lmode = LASER_BAD;
                    lleft = $urandom_range(1, 5);
                end else begin
                    lmode = LASER_NOISE;
                    lleft = $urandom_range(1, 4);
                end
            end
            if (bleft == 0) begin
                pick = $urandom_range(0, 99);
                span = (recover_len > 100) ? 200 : 2 * int'(recover_len) + 2;
                // Trip runs straddle the confirm count so some fall one short.
                if (pick < 25) begin
                    bmode = BEAM_TRIP;
                    bleft = $urandom_range(TRIP_CONFIRM - 5, TRIP_CONFIRM + 20);
                end else if (pick < 65) begin
                    bmode = BEAM_GOOD;
                    bleft = $urandom_range(1, span);
                end else if (pick < 90) begin
                    bmode = BEAM_OTHER;
                    bleft = $urandom_range(1, 6);
                end else begin
                    bmode = BEAM_NOISE;
                    bleft = $urandom_range(1, 4);
                end
            end
            send_sample(laser_value(lmode), beam_value(bmode),
                        (i == count - 1) || ($urandom_range(0, 199) == 0));
            lleft--;
            bleft--;
        end
    endtask

    task automatic load_random_config(input bit wide);
        logic [18:0] lvl;
        logic [17:0] ceil;
        logic [11:0] tl, gl, gh;
        int          top;
        if (wide) begin
            lvl  = 19'($urandom);
            ceil = 18'($urandom);
            tl   = 12'($urandom);
            gl   = 12'($urandom);
            gh   = 12'($urandom);
            load_config(lvl, ceil, 16'($urandom_range(0, 12)), tl, gl, gh,
                        16'($urandom), 16'($urandom_range(0, 12)));
        end else begin
            lvl  = 19'($urandom_range(0, 4000) - 2000);
            ceil = 18'($urandom_range(2500, 262143));
            tl   = 12'($urandom_range(1, 1200));
            gl   = 12'($urandom_range(0, 1500));
            top  = int'(gl) + int'($urandom_range(2, 2500));
            gh   = (top > 4095) ? 12'd4095 : 12'(top);
            load_config(lvl, ceil, 16'($urandom_range(0, 12)), tl, gl, gh,
                        16'($urandom_range(0, 300)), 16'($urandom_range(0, 12)));
        end
    endtask

    task automatic test_reset_defaults();
        send_sample(19'd0, 13'd0, 1'b0);
        send_sample(-19'sd262144, -13'sd4096, 1'b0);
        send_sample(19'd262143, 13'd4095, 1'b0);
        send_sample(19'd1, 13'd320, 1'b0);
        send_sample(-19'sd1, 13'd801, 1'b0);
        send_sample(19'd5, 13'd3199, 1'b1);
        send_sample(19'd0, 13'd0, 1'b1);
        wait_idle();
    endtask

    task automatic test_register_extremes();
        // Zero min run and zero wait act as one; ceiling 0 makes every reading above the level hold.
        load_config(-19'sd262144, 18'd0, 16'd0, 12'd4095, 12'd0, 12'd4095, 16'd0, 16'd0);
        send_sample(-19'sd262144, -13'sd4096, 1'b0);
        send_sample(-19'sd262143, 13'd4095, 1'b0);
        send_sample(19'd0, 13'd1, 1'b0);
        send_sample(19'd262143, 13'd0, 1'b0);
        send_sample(-19'sd262144, 13'd4094, 1'b1);
        wait_idle();

        load_config(19'sd262143, 18'd262143, 16'd2, 12'd0, 12'd4095, 12'd0,
                    16'd65535, 16'd65535);
        send_sample(19'd262143, 13'd1, 1'b0);
        send_sample(-19'sd262144, -13'sd1, 1'b0);
        send_sample(19'd0, 13'd2048, 1'b1);
        wait_idle();

        // Negative level: clear, hold at the ceiling, begin and end on the run end.
        load_config(-19'sd1, 18'd100, 16'd1, 12'd320, 12'd800, 12'd3200, 16'd100, 16'd9600);
        send_sample(-19'sd5, 13'd0, 1'b0);
        send_sample(19'd0, 13'd0, 1'b0);
        send_sample(19'd100, 13'd0, 1'b0);
        send_sample(-19'sd1, 13'd0, 1'b0);
        send_sample(19'd99, 13'd0, 1'b0);
        send_sample(-19'sd1, 13'd0, 1'b1);
        wait_idle();
    endtask

    task automatic test_beam_trip();
        load_config(19'sd0, 18'd262143, 16'd1000, 12'd320, 12'd800, 12'd3200, 16'd0, 16'd3);
        send_beam_run(1, 320, TRIP_CONFIRM);      // index still below the look-back
        send_beam_run(1, 320, 5);
        send_beam_run(801, 3199, 2);
        send_beam_run(800, 800, 1);               // window edges are not good
        send_beam_run(3200, 3200, 1);
        send_beam_run(801, 3199, 3);
        send_beam_run(1, 320, TRIP_CONFIRM - 1);
        send_beam_run(321, 800, 1);
        send_beam_run(1, 320, TRIP_CONFIRM);
        send_beam_run(3199, 3199, 1);
        send_sample(19'd500, 13'd0, 1'b1);        // run end closes the open trip
        wait_idle();

        load_config(19'sd0, 18'd262143, 16'd1000, 12'd320, 12'd800, 12'd3200,
                    16'd65535, 16'd3);
        send_beam_run(1, 320, TRIP_CONFIRM);
        send_sample(19'd500, 13'd1600, 1'b1);
        wait_idle();
    endtask

    task automatic test_trip_overlap();
        // Overlapping windows: confirm and recover on the same sample, then on the sample after.
        load_config(19'sd0, 18'd262143, 16'd1000, 12'd1000, 12'd500, 12'd3000, 16'd7, 16'd1);
        send_beam_run(501, 1000, TRIP_CONFIRM + 2);
        send_sample(19'd500, 13'd0, 1'b1);
        wait_idle();

        load_config(19'sd0, 18'd262143, 16'd1000, 12'd1000, 12'd500, 12'd3000, 16'd7, 16'd2);
        send_beam_run(501, 1000, TRIP_CONFIRM + 1);
        send_sample(19'd500, 13'd0, 1'b1);
        wait_idle();
    endtask

    task automatic test_random_runs();
        load_random_config(1'b0);
        random_samples(RANDOM_RUN_LEN);
        wait_idle();
        random_samples(RANDOM_RUN_LEN);
        wait_idle();

        idle_on = 1'b0;
        load_random_config(1'b0);
        random_samples(RANDOM_RUN_LEN);
        wait_idle();
        idle_on = 1'b1;

        load_random_config(1'b1);
        random_samples(RANDOM_RUN_LEN);
        wait_idle();
    endtask

    initial begin
        reset_model();
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        test_reset_defaults();
        test_register_extremes();
        test_beam_trip();
        test_trip_overlap();
        test_random_runs();
        wait_idle();
        if (mismatches == 0) begin
            $display("laser_off_and_beam_trip_detector_top_tb OK");
        end else begin
            $display("laser_off_and_beam_trip_detector_top_tb NOT OK");
        end
        $finish;
    end

endmodule

[files.f]
hw/rtl/lobt_pkg.sv
hw/rtl/laser_off_and_beam_trip_detector_top.sv
tb/sv/laser_off_and_beam_trip_detector_top_tb.sv
